### hdl/ssc_pkg.sv
`timescale 1ns / 1ps

package ssc_pkg;

    // Operating modes of the clock controller
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_HOURS   = 2'd1;
    localparam logic [1:0] MODE_MINUTES = 2'd2;

    // Configuration register indexes (byte address is four times the index)
    localparam logic [1:0] REG_LONG_PRESS    = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE      = 2'd1;
    localparam logic [1:0] REG_BLOCK_HOLDOFF = 2'd2;
    localparam logic [1:0] REG_EXIT_HOLDOFF  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [11:0] LONG_PRESS_RESET    = 12'd1000;
    localparam logic [11:0] DEBOUNCE_RESET      = 12'd150;
    localparam logic [12:0] BLOCK_HOLDOFF_RESET = 13'd1000;
    localparam logic [12:0] EXIT_HOLDOFF_RESET  = 13'd5000;

    // Saturation value of the press counter
    localparam logic [11:0] COUNT_MAX = 12'hFFF;

    // Wrap limits for time setting
    localparam logic [4:0] HOUR_LAST   = 5'd23;
    localparam logic [5:0] MINUTE_LAST = 6'd59;

    // Configuration register set
    typedef struct packed {
        logic [11:0] long_press_ms;
        logic [11:0] debounce_ms;
        logic [12:0] block_holdoff_ms;
        logic [12:0] exit_holdoff_ms;
    } cfg_t;

    // Clock write request produced by the button logic
    typedef struct packed {
        logic       clock_write;
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic       clear_seconds;
    } wr_req_t;

    // Digit value to seven-segment pattern, bit 0 is segment A
    function automatic logic [6:0] seg_decode(input logic [3:0] value);
        logic [6:0] seg;
        begin
            case (value)
                4'd0:    seg = 7'h3f;
                4'd1:    seg = 7'h06;
                4'd2:    seg = 7'h5b;
                4'd3:    seg = 7'h4f;
                4'd4:    seg = 7'h66;
                4'd5:    seg = 7'h6d;
                4'd6:    seg = 7'h7d;
                4'd7:    seg = 7'h07;
                4'd8:    seg = 7'h7f;
                default: seg = 7'h67;
            endcase
            return seg;
        end
    endfunction

    // Tens digit of a value below 64, found by comparing against multiples of ten
    function automatic logic [2:0] tens_of(input logic [5:0] value);
        logic [2:0] tens;
        begin
            if (value >= 6'd60)
                tens = 3'd6;
            else if (value >= 6'd50)
                tens = 3'd5;
            else if (value >= 6'd40)
                tens = 3'd4;
            else if (value >= 6'd30)
                tens = 3'd3;
            else if (value >= 6'd20)
                tens = 3'd2;
            else if (value >= 6'd10)
                tens = 3'd1;
            else
                tens = 3'd0;
            return tens;
        end
    endfunction

endpackage

### hdl/ssc_regs.sv
`timescale 1ns / 1ps

module ssc_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output ssc_pkg::cfg_t       cfg
);

    logic [11:0] long_press_reg;
    logic [11:0] debounce_reg;
    logic [12:0] block_holdoff_reg;
    logic [12:0] exit_holdoff_reg;
    logic        wr_en;
    logic [1:0]  reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[3:2];

    // Register writes in the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg    <= ssc_pkg::LONG_PRESS_RESET;
            debounce_reg      <= ssc_pkg::DEBOUNCE_RESET;
            block_holdoff_reg <= ssc_pkg::BLOCK_HOLDOFF_RESET;
            exit_holdoff_reg  <= ssc_pkg::EXIT_HOLDOFF_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                ssc_pkg::REG_LONG_PRESS:    long_press_reg    <= pwdata[11:0];
                ssc_pkg::REG_DEBOUNCE:      debounce_reg      <= pwdata[11:0];
                ssc_pkg::REG_BLOCK_HOLDOFF: block_holdoff_reg <= pwdata[12:0];
                ssc_pkg::REG_EXIT_HOLDOFF:  exit_holdoff_reg  <= pwdata[12:0];
                default:                    long_press_reg    <= long_press_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_index)
            ssc_pkg::REG_LONG_PRESS:    prdata = {20'd0, long_press_reg};
            ssc_pkg::REG_DEBOUNCE:      prdata = {20'd0, debounce_reg};
            ssc_pkg::REG_BLOCK_HOLDOFF: prdata = {19'd0, block_holdoff_reg};
            ssc_pkg::REG_EXIT_HOLDOFF:  prdata = {19'd0, exit_holdoff_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.long_press_ms    = long_press_reg;
    assign cfg.debounce_ms      = debounce_reg;
    assign cfg.block_holdoff_ms = block_holdoff_reg;
    assign cfg.exit_holdoff_ms  = exit_holdoff_reg;

endmodule

### hdl/ssc_ctrl.sv
`timescale 1ns / 1ps

module ssc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                button_level,
    input  logic [4:0]          clock_hour,
    input  logic [5:0]          clock_minute,
    input  ssc_pkg::cfg_t       cfg,
    output logic [1:0]          mode_next,
    output logic [1:0]          scan_index,
    output ssc_pkg::wr_req_t    wr_req
);

    logic [1:0]  mode_reg;
    logic [11:0] press_count_reg;
    logic [11:0] press_count_next;
    logic        long_fired_reg;
    logic        long_fired_next;
    logic [11:0] lockout_count_reg;
    logic [11:0] lockout_count_next;
    logic [12:0] holdoff_count_reg;
    logic [12:0] holdoff_count_next;
    logic [1:0]  scan_index_reg;
    logic        last_button_reg;
    logic [11:0] press_inc;
    logic        release_seen;

    assign release_seen = last_button_reg & ~button_level;
    assign press_inc    = (press_count_reg == ssc_pkg::COUNT_MAX) ?
                          press_count_reg : press_count_reg + 12'd1;

    // Button handling for one tick: long press, short press and holdoff
    always_comb
    begin
        mode_next          = mode_reg;
        press_count_next   = press_count_reg;
        long_fired_next    = long_fired_reg;
        holdoff_count_next = holdoff_count_reg;
        wr_req             = '0;

        // The lockout counts down before a release is judged
        if (lockout_count_reg != 12'd0)
            lockout_count_next = lockout_count_reg - 12'd1;
        else
            lockout_count_next = lockout_count_reg;

        if (holdoff_count_reg != 13'd0)
        begin
            holdoff_count_next = holdoff_count_reg - 13'd1;
            press_count_next   = 12'd0;
            if (!button_level)
                long_fired_next = 1'b0;
        end
        else if (button_level)
        begin
            if (!long_fired_reg)
            begin
                if (press_inc >= cfg.long_press_ms)
                begin
                    press_count_next = 12'd0;
                    long_fired_next  = 1'b1;
                    case (mode_reg)
                        ssc_pkg::MODE_HOURS:
                        begin
                            mode_next          = ssc_pkg::MODE_MINUTES;
                            holdoff_count_next = cfg.block_holdoff_ms;
                        end
                        ssc_pkg::MODE_MINUTES:
                        begin
                            mode_next            = ssc_pkg::MODE_NORMAL;
                            holdoff_count_next   = cfg.exit_holdoff_ms;
                            wr_req.clock_write   = 1'b1;
                            wr_req.new_hour      = clock_hour;
                            wr_req.new_minute    = clock_minute;
                            wr_req.clear_seconds = 1'b1;
                        end
                        default:
                        begin
                            mode_next = ssc_pkg::MODE_HOURS;
                        end
                    endcase
                end
                else
                begin
                    press_count_next = press_inc;
                end
            end
        end
        else
        begin
            press_count_next = 12'd0;
            if (release_seen)
            begin
                // The release that ends a long press only re-arms the button
                if (long_fired_reg)
                begin
                    long_fired_next = 1'b0;
                end
                else if ((mode_reg == ssc_pkg::MODE_HOURS ||
                          mode_reg == ssc_pkg::MODE_MINUTES) &&
                         lockout_count_next == 12'd0)
                begin
                    lockout_count_next = cfg.debounce_ms;
                    wr_req.clock_write = 1'b1;
                    if (mode_reg == ssc_pkg::MODE_HOURS)
                    begin
                        wr_req.new_hour      = (clock_hour >= ssc_pkg::HOUR_LAST) ?
                                               5'd0 : clock_hour + 5'd1;
                        wr_req.new_minute    = clock_minute;
                        wr_req.clear_seconds = 1'b0;
                    end
                    else
                    begin
                        wr_req.new_hour      = clock_hour;
                        wr_req.new_minute    = (clock_minute >= ssc_pkg::MINUTE_LAST) ?
                                               6'd0 : clock_minute + 6'd1;
                        wr_req.clear_seconds = 1'b1;
                    end
                end
            end
        end
    end

    // State advances once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= ssc_pkg::MODE_NORMAL;
            press_count_reg   <= 12'd0;
            long_fired_reg    <= 1'b0;
            lockout_count_reg <= 12'd0;
            holdoff_count_reg <= 13'd0;
            scan_index_reg    <= 2'd0;
            last_button_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            press_count_reg   <= press_count_next;
            long_fired_reg    <= long_fired_next;
            lockout_count_reg <= lockout_count_next;
            holdoff_count_reg <= holdoff_count_next;
            scan_index_reg    <= scan_index_reg + 2'd1;
            last_button_reg   <= button_level;
        end
    end

    assign scan_index = scan_index_reg;

endmodule

### hdl/ssc_disp.sv
`timescale 1ns / 1ps

module ssc_disp
(
    input  logic [1:0]  scan_index,
    input  logic [1:0]  mode,
    input  logic [4:0]  clock_hour,
    input  logic [5:0]  clock_minute,
    output logic [6:0]  segment_pattern,
    output logic [3:0]  digit_select_n
);

    logic [2:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [3:0] digit_value;
    logic       blank;
    logic [5:0] hour_wide;
    logic [5:0] hour_rem;
    logic [5:0] minute_rem;

    // Split hour and minute into decimal digits; tens never exceed six here
    assign hour_wide    = {1'b0, clock_hour};
    assign hour_tens    = ssc_pkg::tens_of(hour_wide);
    assign hour_rem     = hour_wide - 6'({hour_tens, 3'b000} + {2'b00, hour_tens, 1'b0});
    assign hour_units   = hour_rem[3:0];
    assign minute_tens  = ssc_pkg::tens_of(clock_minute);
    assign minute_rem   = clock_minute -
                          6'({minute_tens, 3'b000} + {2'b00, minute_tens, 1'b0});
    assign minute_units = minute_rem[3:0];

    // Pick the digit being scanned
    always_comb
    begin
        case (scan_index)
            2'd0:    digit_value = {1'b0, hour_tens};
            2'd1:    digit_value = hour_units;
            2'd2:    digit_value = {1'b0, minute_tens};
            default: digit_value = minute_units;
        endcase
    end

    // The pair of digits not being set is dark
    assign blank = (mode == ssc_pkg::MODE_HOURS && scan_index[1]) ||
                   (mode == ssc_pkg::MODE_MINUTES && !scan_index[1]);

    assign segment_pattern = blank ? 7'd0 : ssc_pkg::seg_decode(digit_value);
    assign digit_select_n  = blank ? 4'hF : ~(4'b0001 << scan_index);

endmodule

### hdl/seven_segment_clock_controller.sv
`timescale 1ns / 1ps

// Multiplexed four-digit seven-segment clock controller. Each input word is one
// millisecond tick carrying the button level and the hour and minute read from
// the real-time clock; each tick yields exactly one output word that drives one
// digit (hour tens, hour units, minute tens, minute units in turn) and, when the
// button sets the time, requests a clock write. While the output side keeps
// taking words, a word is accepted every cycle and the throughput is one word
// per clock; an input register feeds a short stretch of logic into an output
// register, which holds each word until the output side takes it.
// Holding the button for long_press_ms ticks steps normal, set hours, set
// minutes, normal; a short press in a set mode advances the hour or minute.
// Timing registers sit on the APB port at byte addresses 0, 4, 8 and 12.

module seven_segment_clock_controller
(
    input  logic        clk,
    input  logic        rst_n,

    // Input stream: [0] button_level, [5:1] clock_hour, [11:6] clock_minute
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,

    // Output stream: [6:0] segment_pattern, [10:7] digit_select_n,
    // [11] clock_write, [16:12] new_hour, [22:17] new_minute,
    // [23] clear_seconds, [25:24] set_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ssc_pkg::cfg_t    cfg;
    ssc_pkg::wr_req_t wr_req;

    logic        in_valid_reg;
    logic        in_button_reg;
    logic [4:0]  in_hour_reg;
    logic [5:0]  in_minute_reg;
    logic        out_valid_reg;
    logic [25:0] out_data_reg;
    logic        out_advance;
    logic        step;
    logic [1:0]  mode_next;
    logic [1:0]  scan_index;
    logic [6:0]  segment_pattern;
    logic [3:0]  digit_select_n;

    // Handshake: the output register frees when empty or taken
    assign out_advance = !out_valid_reg || m_tready;
    assign step        = in_valid_reg && out_advance;
    assign s_tready    = !in_valid_reg || out_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_button_reg <= s_tdata[0];
            in_hour_reg   <= s_tdata[5:1];
            in_minute_reg <= s_tdata[11:6];
        end
    end

    ssc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .button_level (in_button_reg),
        .clock_hour   (in_hour_reg),
        .clock_minute (in_minute_reg),
        .cfg          (cfg),
        .mode_next    (mode_next),
        .scan_index   (scan_index),
        .wr_req       (wr_req)
    );

    ssc_disp u_disp
    (
        .scan_index      (scan_index),
        .mode            (mode_next),
        .clock_hour      (in_hour_reg),
        .clock_minute    (in_minute_reg),
        .segment_pattern (segment_pattern),
        .digit_select_n  (digit_select_n)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= {mode_next, wr_req.clear_seconds, wr_req.new_minute,
                             wr_req.new_hour, wr_req.clock_write,
                             digit_select_n, segment_pattern};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_LIMIT  = 20000;

    // One displayed digit as it leaves the block, segment pattern in the low bits
    typedef struct packed {
        logic [1:0] set_mode;
        logic       clear_seconds;
        logic [5:0] new_minute;
        logic [4:0] new_hour;
        logic       clock_write;
        logic [3:0] digit_select_n;
        logic [6:0] segment_pattern;
    } display_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted controller state and timing registers
    ssc_pkg::cfg_t timing;
    logic [1:0]    cur_mode;
    logic [11:0]   press_ticks;
    logic          long_done;
    logic [11:0]   lockout_left;
    logic [12:0]   holdoff_left;
    logic [1:0]    scan_pos;
    logic          last_btn;

    display_word_t expected_digits[$];

    int  mismatches = 0;
    int  words_seen = 0;
    int  ticks_sent = 0;
    int  writes_expected = 0;
    int  mode_changes = 0;
    int  settings_applied = 0;
    int  cycles = 0;
    int  sink_hold_cycles = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;

    seven_segment_clock_controller dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // Segment pattern of a decimal digit, bit 0 is segment A.
    function automatic logic [6:0] segments_for(input int shown);
        case (shown)
            0:       return 7'h3f;
            1:       return 7'h06;
            2:       return 7'h5b;
            3:       return 7'h4f;
            4:       return 7'h66;
            5:       return 7'h6d;
            6:       return 7'h7d;
            7:       return 7'h07;
            8:       return 7'h7f;
            default: return 7'h67;
        endcase
    endfunction

    // Advances the predicted controller by one tick and returns the digit it shows.
    function automatic display_word_t predict_digit(input logic btn, input logic [4:0] hr,
                                                    input logic [5:0] mn);
        display_word_t w;
        logic          released;
        logic          blank;
        logic [1:0]    prior_mode;
        int            shown;
        int            pos;
        w = '0;
        released = last_btn && !btn;
        prior_mode = cur_mode;
        if (lockout_left != 0)
            lockout_left = lockout_left - 12'd1;

        if (holdoff_left != 0)
        begin
            // Button ignored while the holdoff runs out.
            holdoff_left = holdoff_left - 13'd1;
            press_ticks = '0;
            if (!btn)
                long_done = 1'b0;
        end
        else if (btn)
        begin
            if (!long_done)
            begin
                if (press_ticks != ssc_pkg::COUNT_MAX)
                    press_ticks = press_ticks + 12'd1;
                if (press_ticks >= timing.long_press_ms)
                begin
                    press_ticks = '0;
                    long_done = 1'b1;
                    case (cur_mode)
                        ssc_pkg::MODE_NORMAL:
                            cur_mode = ssc_pkg::MODE_HOURS;
                        ssc_pkg::MODE_HOURS:
                        begin
                            cur_mode = ssc_pkg::MODE_MINUTES;
                            holdoff_left = timing.block_holdoff_ms;
                        end
                        default:
                        begin
                            cur_mode = ssc_pkg::MODE_NORMAL;
                            holdoff_left = timing.exit_holdoff_ms;
                            w.clock_write = 1'b1;
                            w.new_hour = hr;
                            w.new_minute = mn;
                            w.clear_seconds = 1'b1;
                        end
                    endcase
                end
            end
        end
        else
        begin
            press_ticks = '0;
            if (released)
            begin
                // The release that ends a long press never counts as a step.
                if (long_done)
                begin
                    long_done = 1'b0;
                end
                else if (cur_mode != ssc_pkg::MODE_NORMAL && lockout_left == 0)
                begin
                    lockout_left = timing.debounce_ms;
                    w.clock_write = 1'b1;
                    if (cur_mode == ssc_pkg::MODE_HOURS)
                    begin
                        w.new_hour = (hr >= ssc_pkg::HOUR_LAST) ? 5'd0 : hr + 5'd1;
                        w.new_minute = mn;
                    end
                    else
                    begin
                        w.new_hour = hr;
                        w.new_minute = (mn >= ssc_pkg::MINUTE_LAST) ? 6'd0 : mn + 6'd1;
                        w.clear_seconds = 1'b1;
                    end
                end
            end
        end

        // Show the scanned digit, blanking the pair that is not being set.
        pos = scan_pos;
        case (pos)
            0:       shown = hr / 10;
            1:       shown = hr % 10;
            2:       shown = mn / 10;
            default: shown = mn % 10;
        endcase
        blank = (cur_mode == ssc_pkg::MODE_HOURS && pos >= 2) ||
                (cur_mode == ssc_pkg::MODE_MINUTES && pos < 2);
        if (blank)
        begin
            w.segment_pattern = '0;
            w.digit_select_n = 4'hF;
        end
        else
        begin
            w.segment_pattern = segments_for(shown);
            w.digit_select_n = ~(4'b0001 << pos);
        end
        scan_pos = scan_pos + 2'd1;
        last_btn = btn;
        w.set_mode = cur_mode;
        if (cur_mode != prior_mode)
            mode_changes++;
        if (w.clock_write)
            writes_expected++;
        return w;
    endfunction

    function automatic int pick_idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Hours and minutes mostly in range, sometimes anywhere in the field.
    function automatic logic [4:0] any_hour();
        if ($urandom_range(0, 4) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 23));
    endfunction

    function automatic logic [5:0] any_minute();
        if ($urandom_range(0, 4) == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, 59));
    endfunction

    task automatic check_value(input string what, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch in %s after %0d words: expected %0d, got %0d",
                         what, words_seen, want, got);
        end
    endtask

    // Offers one tick and records its expected digit once it is taken.
    task automatic send_tick(input logic btn, input logic [4:0] hr, input logic [5:0] mn);
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, mn, hr, btn};
        do
            @(posedge clk);
        while (!s_tready);
        expected_digits.push_back(predict_digit(btn, hr, mn));
        ticks_sent++;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat (pick_idle_len()) @(posedge clk);
        end
    endtask

    // Stops offering ticks until every expected word has come back.
    task automatic wait_display_drained();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (expected_digits.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    task automatic check_reg(input logic [1:0] index, input logic [12:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {index, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_value("register readback", value, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= {19'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (index)
            ssc_pkg::REG_LONG_PRESS:    timing.long_press_ms = value[11:0];
            ssc_pkg::REG_DEBOUNCE:      timing.debounce_ms = value[11:0];
            ssc_pkg::REG_BLOCK_HOLDOFF: timing.block_holdoff_ms = value;
            default:                    timing.exit_holdoff_ms = value;
        endcase
        check_reg(index, value);
    endtask

    // Changes all timing registers once the display pipeline is empty.
    task automatic apply_settings(input int long_press, input int debounce,
                                  input int block_holdoff, input int exit_holdoff);
        wait_display_drained();
        repeat (4) @(posedge clk);
        write_reg(ssc_pkg::REG_LONG_PRESS, 13'(long_press));
        write_reg(ssc_pkg::REG_DEBOUNCE, 13'(debounce));
        write_reg(ssc_pkg::REG_BLOCK_HOLDOFF, 13'(block_holdoff));
        write_reg(ssc_pkg::REG_EXIT_HOLDOFF, 13'(exit_holdoff));
        settings_applied++;
    endtask

    task automatic press_for(input int held, input int idle);
        repeat (held) send_tick(1'b1, any_hour(), any_minute());
        repeat (idle) send_tick(1'b0, any_hour(), any_minute());
    endtask

    // Random button gestures: short presses, long presses, idle time and bounce.
    task automatic run_gestures(input int ticks);
        int start;
        int pick;
        int lp;
        int deb;
        start = ticks_sent;
        lp = timing.long_press_ms;
        if (lp == 0)
            lp = 1;
        if (lp > 40)
            lp = 40;
        deb = (timing.debounce_ms < 10) ? timing.debounce_ms : 10;
        while (ticks_sent - start < ticks)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                press_for($urandom_range(1, (lp > 1) ? lp - 1 : 1), $urandom_range(1, deb + 2));
            else if (pick < 65)
                press_for(lp + $urandom_range(0, 3), $urandom_range(1, 3));
            else if (pick < 85)
                press_for(0, $urandom_range(1, 6));
            else
                repeat ($urandom_range(1, 8))
                    send_tick(1'($urandom_range(0, 1)), any_hour(), any_minute());
            if (pick % 23 == 0)
                wait_display_drained();
        end
    endtask

    task automatic test_register_access();
        check_reg(ssc_pkg::REG_LONG_PRESS, {1'b0, ssc_pkg::LONG_PRESS_RESET});
        check_reg(ssc_pkg::REG_DEBOUNCE, {1'b0, ssc_pkg::DEBOUNCE_RESET});
        check_reg(ssc_pkg::REG_BLOCK_HOLDOFF, ssc_pkg::BLOCK_HOLDOFF_RESET);
        check_reg(ssc_pkg::REG_EXIT_HOLDOFF, ssc_pkg::EXIT_HOLDOFF_RESET);
    endtask

    // A press of one tick is long: walk through all three modes.
    task automatic test_mode_stepping();
        apply_settings(1, 0, 0, 0);
        send_tick(1'b0, 5'd0, 6'd0);
        send_tick(1'b0, 5'd23, 6'd59);
        send_tick(1'b0, 5'd31, 6'd63);
        send_tick(1'b1, 5'd31, 6'd63);
        send_tick(1'b0, 5'd23, 6'd59);
        send_tick(1'b1, 5'd20, 6'd30);
        send_tick(1'b0, 5'd16, 6'd32);
        send_tick(1'b1, 5'd10, 6'd45);
        send_tick(1'b0, 5'd5, 6'd5);
    endtask

    task automatic test_time_setting();
        apply_settings(3, 3, 2, 3);
        // Enter set hours; the release that ends it is not a step.
        press_for(3, 0);
        send_tick(1'b0, 5'd7, 6'd12);
        // Hour wraps after 23, a second press inside the lockout is dropped.
        send_tick(1'b1, 5'd23, 6'd40);
        send_tick(1'b0, 5'd23, 6'd40);
        send_tick(1'b1, 5'd9, 6'd1);
        send_tick(1'b0, 5'd9, 6'd1);
        send_tick(1'b1, 5'd31, 6'd2);
        send_tick(1'b0, 5'd31, 6'd2);
        // Move to set minutes, then press and release inside the block holdoff.
        press_for(3, 0);
        send_tick(1'b1, 5'd12, 6'd20);
        send_tick(1'b0, 5'd12, 6'd20);
        // Minute wraps after 59.
        send_tick(1'b1, 5'd12, 6'd59);
        send_tick(1'b0, 5'd12, 6'd59);
        // Leave set mode with a full write, then a release in normal mode.
        press_for(3, 3);
        send_tick(1'b1, 5'd18, 6'd63);
        send_tick(1'b0, 5'd18, 6'd63);
    endtask

    task automatic test_random_sessions();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        apply_settings(1, 0, 0, 0);
        run_gestures(150);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        repeat (3)
        begin
            apply_settings($urandom_range(2, 6), $urandom_range(0, 8),
                           $urandom_range(0, 12), $urandom_range(0, 12));
            run_gestures(190);
        end
    endtask

    // Output held off for a long stretch while ticks keep coming.
    task automatic test_backpressure();
        gaps_on = 1'b0;
        sink_hold_cycles = 300;
        run_gestures(60);
        wait_display_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_long_timers();
        apply_settings(4095, 4095, 8191, 8191);
        run_gestures(60);
        apply_settings(3, 4095, 0, 8191);
        run_gestures(200);
    endtask

    // Output side: random stalls, plus a long hold-off when one is requested.
    initial
    begin : output_sink
        int stall_len;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                stall_len = sink_hold_cycles;
                sink_hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (stall_len - 1) @(posedge clk);
            end
            else if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                stall_len = pick_idle_len();
                m_tready <= 1'b0;
                repeat (stall_len - 1) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compares every word taken from the block with the oldest prediction.
    initial
    begin : display_checker
        display_word_t got;
        display_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = m_tdata[25:0];
                words_seen++;
                if (expected_digits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Word %0d arrived with no tick waiting for it", words_seen);
                end
                else
                begin
                    want = expected_digits.pop_front();
                    check_value("segment_pattern", want.segment_pattern, got.segment_pattern);
                    check_value("digit_select_n", want.digit_select_n, got.digit_select_n);
                    check_value("clock_write", want.clock_write, got.clock_write);
                    check_value("new_hour", want.new_hour, got.new_hour);
                    check_value("new_minute", want.new_minute, got.new_minute);
                    check_value("clear_seconds", want.clear_seconds, got.clear_seconds);
                    check_value("set_mode", want.set_mode, got.set_mode);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles", cycles);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : test_sequence
        timing.long_press_ms = ssc_pkg::LONG_PRESS_RESET;
        timing.debounce_ms = ssc_pkg::DEBOUNCE_RESET;
        timing.block_holdoff_ms = ssc_pkg::BLOCK_HOLDOFF_RESET;
        timing.exit_holdoff_ms = ssc_pkg::EXIT_HOLDOFF_RESET;
        cur_mode = ssc_pkg::MODE_NORMAL;
        press_ticks = '0;
        long_done = 1'b0;
        lockout_left = '0;
        holdoff_left = '0;
        scan_pos = '0;
        last_btn = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_mode_stepping();
        test_time_setting();
        test_random_sessions();
        test_backpressure();
        test_long_timers();

        wait_display_drained();
        repeat (8) @(posedge clk);
        if (expected_digits.size() != 0)
        begin
            mismatches += expected_digits.size();
            $display("%0d expected words never arrived", expected_digits.size());
        end

        $display("Covered %0d ticks, %0d clock writes and %0d mode changes", ticks_sent,
                 writes_expected, mode_changes);
        $display("under %0d timing settings, with input gaps and output stalls.",
                 settings_applied);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
